@@ rtl/core/hrpc_pkg.sv @@
// Types and constants shared by the heading rotation P-controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package hrpc_pkg;

   // Q3.12 angle constants, sized to the error datapath
   localparam logic signed [17:0] QPi    = 18'sd12868;
   localparam logic signed [17:0] QTwoPi = 18'sd25736;

   localparam logic [7:0] TickMax = 8'd255;

   // Register indexes on the CSR port
   localparam logic [2:0] CsrTargetRotation = 3'd0;
   localparam logic [2:0] CsrGain           = 3'd1;
   localparam logic [2:0] CsrMaxSpeed       = 3'd2;
   localparam logic [2:0] CsrMinSpeed       = 3'd3;
   localparam logic [2:0] CsrArriveThresh   = 3'd4;
   localparam logic [2:0] CsrTimeoutTicks   = 3'd5;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ARMED = 2'd1,
      PH_ROT   = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_CAPTURE  = 3'd1,
      ST_ROTATING = 3'd2,
      ST_DONE     = 3'd3,
      ST_TIMEOUT  = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [15:0] target_rotation;
      logic [11:0]        gain;
      logic [14:0]        max_speed;
      logic [14:0]        min_speed;
      logic [14:0]        arrive_threshold;
      logic [7:0]         timeout_ticks;
   } cfg_type;

   // Wrapped heading error as magnitude and sign
   typedef struct packed {
      logic [13:0] mag;
      logic        pos;
   } err_type;

endpackage

`default_nettype wire

@@ rtl/core/hrpc_err.sv @@
// Heading error: goal minus heading, wrapped into plus/minus pi, split into magnitude and sign.
// Depends on hrpc_pkg.
`default_nettype none

module hrpc_err (
   input  wire logic signed [16:0] goal_angle,
   input  wire logic signed [14:0] current_angle,
   output hrpc_pkg::err_type       err
);
   import hrpc_pkg::*;

   logic signed [17:0] diff;
   logic signed [17:0] wrapped;
   logic signed [17:0] magnitude;

   assign diff = {goal_angle[16], goal_angle} - {{3{current_angle[14]}}, current_angle};

   // The difference spans at most about five half turns, so three corrections at most
   always_comb begin
      if (diff > QPi + QTwoPi + QTwoPi) begin
         wrapped = diff - QTwoPi - QTwoPi - QTwoPi;
      end else if (diff > QPi + QTwoPi) begin
         wrapped = diff - QTwoPi - QTwoPi;
      end else if (diff > QPi) begin
         wrapped = diff - QTwoPi;
      end else if (diff < -QPi - QTwoPi - QTwoPi) begin
         wrapped = diff + QTwoPi + QTwoPi + QTwoPi;
      end else if (diff < -QPi - QTwoPi) begin
         wrapped = diff + QTwoPi + QTwoPi;
      end else if (diff < -QPi) begin
         wrapped = diff + QTwoPi;
      end else begin
         wrapped = diff;
      end
   end

   assign magnitude = wrapped[17] ? -wrapped : wrapped;
   assign err.mag   = magnitude[13:0];
   assign err.pos   = (wrapped > 18'sd0);

endmodule

`default_nettype wire

@@ rtl/core/hrpc_speed.sv @@
// Proportional speed law: gain times error, rounded, clamped to max then raised to min.
// Depends on hrpc_pkg.
`default_nettype none

module hrpc_speed (
   input  wire hrpc_pkg::err_type  err,
   input  wire hrpc_pkg::cfg_type  cfg,
   output logic signed [15:0]      angular_speed
);
   import hrpc_pkg::*;

   logic [25:0] product;
   logic [17:0] rounded;
   logic [14:0] clamped;
   logic [14:0] chosen;
   logic        negative;

   // Q4.8 x Q3.12, round half away from zero on the magnitude
   assign product = 26'(cfg.gain) * 26'(err.mag) + 26'd128;
   assign rounded = product[25:8];
   assign clamped = (rounded > {3'b000, cfg.max_speed}) ? cfg.max_speed : rounded[14:0];

   always_comb begin
      if (clamped == 15'd0) begin
         chosen   = cfg.min_speed;
         negative = 1'b1;       // zero command takes the negative minimum
      end else if (clamped < cfg.min_speed) begin
         chosen   = cfg.min_speed;
         negative = !err.pos;
      end else begin
         chosen   = clamped;
         negative = !err.pos;
      end
   end

   assign angular_speed = negative ? -$signed({1'b0, chosen}) : $signed({1'b0, chosen});

endmodule

`default_nettype wire

@@ rtl/core/heading_rotation_p_controller_core.sv @@
// Heading rotation P-controller: input register, single-pass control law, result register.
// A result is registered as its transaction leaves the input stage.
// Throughput: one transaction per cycle; the input stalls only while both the input
// and result stages hold transactions and rsp_ready is low.
// Reset: synchronous; configuration registers return to their defaults, phase idle, goal and ticks zero.
// Depends on hrpc_pkg, hrpc_err, hrpc_speed.
`default_nettype none

module heading_rotation_p_controller_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_func,
   input  wire logic signed [14:0] req_current_angle,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_angular_speed,
   output logic [2:0]              rsp_status,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_write_data
);
   import hrpc_pkg::*;

   cfg_type            cfg_ff;
   phase_type          phase_ff, phase_in;
   logic signed [16:0] goal_ff, goal_in;
   logic [7:0]         tick_ff, tick_in;

   logic               s1_valid_ff;
   logic               s1_func_ff;
   logic signed [14:0] s1_angle_ff;

   logic               rsp_valid_ff;
   logic signed [15:0] speed_ff, speed_in;
   status_type         status_ff, status_in;

   logic               advance;
   err_type            err;
   logic signed [15:0] law_speed;
   logic [7:0]         tick_next;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_rotation  <= 16'sd0;
         cfg_ff.gain             <= 12'd384;
         cfg_ff.max_speed        <= 15'd4096;
         cfg_ff.min_speed        <= 15'd205;
         cfg_ff.arrive_threshold <= 15'd205;
         cfg_ff.timeout_ticks    <= 8'd200;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrTargetRotation: cfg_ff.target_rotation  <= $signed(csr_write_data);
            CsrGain:           cfg_ff.gain             <= csr_write_data[11:0];
            CsrMaxSpeed:       cfg_ff.max_speed        <= csr_write_data[14:0];
            CsrMinSpeed:       cfg_ff.min_speed        <= csr_write_data[14:0];
            CsrArriveThresh:   cfg_ff.arrive_threshold <= csr_write_data[14:0];
            CsrTimeoutTicks:   cfg_ff.timeout_ticks    <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_func_ff  <= req_func;
         s1_angle_ff <= req_current_angle;
      end
   end

   hrpc_err u_err (
      .goal_angle    (goal_ff),
      .current_angle (s1_angle_ff),
      .err           (err)
   );

   hrpc_speed u_speed (
      .err           (err),
      .cfg           (cfg_ff),
      .angular_speed (law_speed)
   );

   assign tick_next = (tick_ff == TickMax) ? TickMax : tick_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      goal_in   = goal_ff;
      tick_in   = tick_ff;
      speed_in  = 16'sd0;
      status_in = ST_IDLE;
      if (s1_func_ff) begin
         phase_in = PH_ARMED;
         tick_in  = 8'd0;
      end else begin
         unique case (phase_ff)
            PH_ARMED: begin
               goal_in   = {{2{s1_angle_ff[14]}}, s1_angle_ff}
                         + {cfg_ff.target_rotation[15], cfg_ff.target_rotation};
               phase_in  = PH_ROT;
               status_in = ST_CAPTURE;
            end
            PH_ROT: begin
               if ({1'b0, err.mag} < cfg_ff.arrive_threshold) begin
                  phase_in  = PH_STOP;
                  status_in = ST_DONE;
               end else begin
                  tick_in = tick_next;
                  if (tick_next >= cfg_ff.timeout_ticks) begin
                     phase_in  = PH_STOP;
                     status_in = ST_TIMEOUT;
                  end else begin
                     speed_in  = law_speed;
                     status_in = ST_ROTATING;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Controller state, committed as each transaction leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         goal_ff  <= 17'sd0;
         tick_ff  <= 8'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         goal_ff  <= goal_in;
         tick_ff  <= tick_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         speed_ff  <= speed_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_angular_speed = speed_ff;
   assign rsp_status        = status_ff;

endmodule

`default_nettype wire
